[rtl/core/e2q_pkg.sv]
// constants and types for the euler angle to quaternion core
// cordic arctangent table and fixed-point widths; no dependencies
`default_nettype none
package e2q_pkg;
   localparam int CordicIters = 32;
   localparam int IntFrac = 30;
   localparam int CordicW = 34;
   localparam int ZW = 35;
   localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;

   typedef logic signed [CordicW-1:0] cq_type;
   typedef logic signed [ZW-1:0] za_type;

   typedef struct packed {
      cq_type c;
      cq_type s;
   } sincos_type;

   function automatic za_type atan_tab(input int i);
      za_type t;
      unique case (i)
         0: t = 35'sd1073741824;   1: t = 35'sd633866813;
         2: t = 35'sd334917814;    3: t = 35'sd170009512;
         4: t = 35'sd85334662;     5: t = 35'sd42708930;
         6: t = 35'sd21359676;     7: t = 35'sd10680490;
         8: t = 35'sd5340326;      9: t = 35'sd2670174;
         10: t = 35'sd1335088;     11: t = 35'sd667544;
         12: t = 35'sd333772;      13: t = 35'sd166886;
         14: t = 35'sd83443;       15: t = 35'sd41722;
         16: t = 35'sd20861;       17: t = 35'sd10430;
         18: t = 35'sd5215;        19: t = 35'sd2608;
         20: t = 35'sd1304;        21: t = 35'sd652;
         22: t = 35'sd326;         23: t = 35'sd163;
         24: t = 35'sd81;          25: t = 35'sd41;
         26: t = 35'sd20;          27: t = 35'sd10;
         28: t = 35'sd5;           29: t = 35'sd3;
         30: t = 35'sd1;           31: t = 35'sd1;
         default: t = '0;
      endcase
      return t;
   endfunction

   // q30 product, rounded half up
   function automatic cq_type mulq(input cq_type a, input cq_type b);
      logic signed [2*CordicW-1:0] p;
      p = a * b + (68'sd1 <<< (IntFrac - 1));
      return cq_type'(p >>> IntFrac);
   endfunction
endpackage
`default_nettype wire

[rtl/core/e2q_cordic_stage.sv]
// one pipelined rotation-mode cordic iteration for three angles
// uses e2q_pkg
`default_nettype none
module e2q_cordic_stage
   import e2q_pkg::*;
#(
   parameter int Iter = 0
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       adv,
   input  wire logic       vld_i,
   input  wire sincos_type cs_i [3],
   input  wire za_type     z_i [3],
   output logic            vld_o,
   output sincos_type      cs_o [3],
   output za_type          z_o [3]
);
   logic       vld_ff;
   sincos_type cs_ff [3];
   za_type     z_ff [3];
   sincos_type cs_in [3];
   za_type     z_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (!z_i[k][ZW-1]) begin
            cs_in[k].c = cs_i[k].c - (cs_i[k].s >>> Iter);
            cs_in[k].s = cs_i[k].s + (cs_i[k].c >>> Iter);
            z_in[k] = z_i[k] - atan_tab(Iter);
         end else begin
            cs_in[k].c = cs_i[k].c + (cs_i[k].s >>> Iter);
            cs_in[k].s = cs_i[k].s - (cs_i[k].c >>> Iter);
            z_in[k] = z_i[k] + atan_tab(Iter);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (adv) vld_ff <= vld_i;
      if (adv) begin
         cs_ff <= cs_in;
         z_ff <= z_in;
      end
   end

   assign vld_o = vld_ff;
   assign cs_o = cs_ff;
   assign z_o = z_ff;
endmodule
`default_nettype wire

[rtl/core/e2q_combine.sv]
// product stages forming the quaternion from half-angle sines and cosines
// uses e2q_pkg
`default_nettype none
module e2q_combine
   import e2q_pkg::*;
#(
   parameter int OutFracBits = 14
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       adv,
   input  wire logic       vld_i,
   input  wire sincos_type cs_i [3],
   output logic            vld_o,
   output logic [4*(OutFracBits+2)-1:0] quat_o
);
   localparam int OW = OutFracBits + 2;
   localparam int Sh = IntFrac - OutFracBits;

   logic [2:0] vld_ff;
   cq_type cpcy_ff, spsy_ff, crsp_ff, srcp_ff, crcp_ff, srsp_ff;
   cq_type cr1_ff, sr1_ff, cy1_ff, sy1_ff;
   cq_type pw_ff [8];
   logic [4*OW-1:0] quat_ff;

   function automatic logic [OW-1:0] to_out(input cq_type v);
      logic signed [CordicW:0] r;
      logic signed [CordicW:0] lim;
      r = (CordicW+1)'(v) + ((CordicW+1)'(1) <<< (Sh - 1));
      r = r >>> Sh;
      lim = (CordicW+1)'(1) <<< OutFracBits;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[OW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[1:0], vld_i};
      if (adv) begin
         cpcy_ff <= mulq(cs_i[1].c, cs_i[2].c);
         spsy_ff <= mulq(cs_i[1].s, cs_i[2].s);
         crsp_ff <= mulq(cs_i[0].c, cs_i[1].s);
         srcp_ff <= mulq(cs_i[0].s, cs_i[1].c);
         crcp_ff <= mulq(cs_i[0].c, cs_i[1].c);
         srsp_ff <= mulq(cs_i[0].s, cs_i[1].s);
         cr1_ff <= cs_i[0].c;
         sr1_ff <= cs_i[0].s;
         cy1_ff <= cs_i[2].c;
         sy1_ff <= cs_i[2].s;
         pw_ff[0] <= mulq(cr1_ff, cpcy_ff);
         pw_ff[1] <= mulq(sr1_ff, spsy_ff);
         pw_ff[2] <= mulq(sr1_ff, cpcy_ff);
         pw_ff[3] <= mulq(cr1_ff, spsy_ff);
         pw_ff[4] <= mulq(crsp_ff, cy1_ff);
         pw_ff[5] <= mulq(srcp_ff, sy1_ff);
         pw_ff[6] <= mulq(crcp_ff, sy1_ff);
         pw_ff[7] <= mulq(srsp_ff, cy1_ff);
         quat_ff <= {to_out(pw_ff[6] - pw_ff[7]), to_out(pw_ff[4] + pw_ff[5]),
                     to_out(pw_ff[2] - pw_ff[3]), to_out(pw_ff[0] + pw_ff[1])};
      end
   end

   assign vld_o = vld_ff[2];
   assign quat_o = quat_ff;
endmodule
`default_nettype wire

[rtl/core/euler_to_quaternion_core.sv]
// euler angles to quaternion, top level
// 32 cordic stages followed by 3 product stages
// throughput one item per clock; a stalled output holds the whole pipeline
// reset clears all valid bits; payload registers are not reset
// uses e2q_pkg, e2q_cordic_stage, e2q_combine
`default_nettype none
module euler_to_quaternion_core
   import e2q_pkg::*;
#(
   parameter int ANGLE_BITS = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // roll_angle, pitch_angle, yaw_angle
   input  wire logic [((3*ANGLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // quat_w, quat_x, quat_y, quat_z
   output logic [((4*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] rsp_tdata
);
   localparam int OW = OUT_FRAC_BITS + 2;
   localparam int RW = ((4*OW+7)/8)*8;

   logic       adv;
   logic       vld [CordicIters+1];
   sincos_type cs [CordicIters+1][3];
   za_type     z [CordicIters+1][3];
   logic       out_vld;
   logic [4*OW-1:0] quat;

   assign adv = rsp_tready || !rsp_tvalid;
   assign req_tready = adv;
   assign vld[0] = req_tvalid;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cs[0][k].c = CordicGain;
         cs[0][k].s = '0;
         z[0][k] = ZW'($signed(req_tdata[k*ANGLE_BITS +: ANGLE_BITS]))
                   <<< (32 - ANGLE_BITS);
      end
   end

   for (genvar i = 0; i < CordicIters; i++) begin : g_stage
      e2q_cordic_stage #(.Iter(i)) u_stage (
         .clock(clock), .reset(reset), .adv(adv),
         .vld_i(vld[i]), .cs_i(cs[i]), .z_i(z[i]),
         .vld_o(vld[i+1]), .cs_o(cs[i+1]), .z_o(z[i+1])
      );
   end

   e2q_combine #(.OutFracBits(OUT_FRAC_BITS)) u_combine (
      .clock(clock), .reset(reset), .adv(adv),
      .vld_i(vld[CordicIters]), .cs_i(cs[CordicIters]),
      .vld_o(out_vld), .quat_o(quat)
   );

   assign rsp_tvalid = out_vld;
   assign rsp_tdata = RW'(quat);
endmodule
`default_nettype wire

[tb/euler_to_quaternion_core_checker.sv]
`timescale 1ns / 100ps
// checker for the euler angle to quaternion core: watches both streams,
// predicts each quaternion with its own cordic and products, compares fields
`default_nettype none
module euler_to_quaternion_core_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   input  wire logic req_tready,
   input  wire logic [47:0] req_tdata,
   input  wire logic rsp_tvalid,
   input  wire logic rsp_tready,
   input  wire logic [63:0] rsp_tdata,
   output int errors,
   output int pending
);
   typedef struct {
      logic signed [15:0] w;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } quat_type;

   quat_type quat_q[$];
   longint atan_q33[32] = '{
      1073741824, 633866813, 334917814, 170009512, 85334662, 42708930, 21359676,
      10680490, 5340326, 2670174, 1335088, 667544, 333772, 166886, 83443, 41722,
      20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};

   function automatic longint q30_mul(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic void half_sincos(logic signed [15:0] ang, output longint c,
                                       output longint s);
      longint xv, yv, zv, dx, dy;
      xv = 652032874;
      yv = 0;
      zv = longint'(ang) * 65536;
      for (int i = 0; i < 32; i++) begin
         dx = yv >>> i;
         dy = xv >>> i;
         if (zv >= 0) begin
            xv -= dx; yv += dy; zv -= atan_q33[i];
         end else begin
            xv += dx; yv -= dy; zv += atan_q33[i];
         end
      end
      c = xv;
      s = yv;
   endfunction

   function automatic logic signed [15:0] to_q14(longint v);
      longint r;
      r = (v + 32768) >>> 16;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
   endfunction

   function automatic quat_type euler_quat(logic [47:0] d);
      longint cr, sr, cp, sp, cy, sy, cpcy, spsy;
      quat_type q;
      half_sincos(d[15:0], cr, sr);
      half_sincos(d[31:16], cp, sp);
      half_sincos(d[47:32], cy, sy);
      cpcy = q30_mul(cp, cy);
      spsy = q30_mul(sp, sy);
      q.w = to_q14(q30_mul(cr, cpcy) + q30_mul(sr, spsy));
      q.x = to_q14(q30_mul(sr, cpcy) - q30_mul(cr, spsy));
      q.y = to_q14(q30_mul(q30_mul(cr, sp), cy) + q30_mul(q30_mul(sr, cp), sy));
      q.z = to_q14(q30_mul(q30_mul(cr, cp), sy) - q30_mul(q30_mul(sr, sp), cy));
      return q;
   endfunction

   always @(posedge clock) begin
      quat_type e;
      if (!reset && req_tvalid && req_tready) quat_q.push_back(euler_quat(req_tdata));
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (quat_q.size() == 0) begin
            errors <= errors + 1;
            if (errors < 10) $display("unexpected item %h", rsp_tdata);
         end else begin
            e = quat_q.pop_front();
            if (rsp_tdata !== {e.z, e.y, e.x, e.w}) begin
               errors <= errors + 1;
               if (errors < 10)
                  $display("mismatch exp w %0d x %0d y %0d z %0d got %h",
                           e.w, e.x, e.y, e.z, rsp_tdata);
            end
         end
      end
      pending <= quat_q.size();
   end
endmodule
`default_nettype wire

[tb/euler_to_quaternion_core_tb.sv]
`timescale 1ns / 100ps
// testbench top for the euler angle to quaternion core: drives angle triples
// with random gaps and stalls; depends on the core and its checker
`default_nettype none
module euler_to_quaternion_core_tb;
   logic clock = 0, reset = 1;
   logic req_tvalid = 0, rsp_tready = 0;
   logic [47:0] req_tdata = '0;
   logic req_tready, rsp_tvalid;
   logic [63:0] rsp_tdata;
   int errors, pending, idle_cycles, gap, stall;
   bit calm, timed_out;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   euler_to_quaternion_core dut (.*);
   euler_to_quaternion_core_checker chk (.*);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
         $display("[euler_to_quaternion_core] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (calm || reset) rsp_tready <= !reset;
      else if (stall > 0) begin
         stall <= stall - 1;
         rsp_tready <= 0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall <= $urandom_range(1, 10) - 1;
         rsp_tready <= 0;
      end else rsp_tready <= 1;
   end

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return {2'($urandom_range(0, 3)), 14'h0};
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic send(logic [47:0] d);
      req_tdata <= d;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   initial begin
      logic [15:0] dir[8] = '{16'h0000, 16'h8000, 16'h7fff, 16'h4000, 16'hc000,
                              16'h0001, 16'hffff, 16'h2000};
      calm = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int i = 0; i < 24; i++)
         send({dir[(i / 8) % 8], dir[(i + 3) % 8], dir[i % 8]});
      for (int i = 0; i < 650; i++) begin
         if (i == 560) calm = 1;
         send({pick_angle(), pick_angle(), pick_angle()});
      end
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) $display("[euler_to_quaternion_core] OK");
      else $display("[euler_to_quaternion_core] ERROR");
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
rtl/core/e2q_pkg.sv
rtl/core/e2q_cordic_stage.sv
rtl/core/e2q_combine.sv
rtl/core/euler_to_quaternion_core.sv
tb/euler_to_quaternion_core_checker.sv
tb/euler_to_quaternion_core_tb.sv
